@@ hdl/mmsr_pkg.sv @@
// Package for the masked minimal-standard generator.
// Item types, constants, sequencer states and datapath operation codes.
package mmsr_pkg;

  localparam logic [31:0] MASK_WORD  = 32'h075B_D924;
  localparam logic [14:0] MULTIPLIER = 15'h41A7;
  localparam logic [30:0] MODULUS    = 31'h7FFF_FFFF;
  localparam logic [32:0] TWO_MOD    = 33'h0_FFFF_FFFE;
  localparam logic [7:0]  EXP_BASE   = 8'd96;
  localparam logic [4:0]  TOP_POS    = 5'd30;

  typedef struct packed {
    logic               command;
    logic signed [31:0] seed_value;
  } in_item_t;

  typedef struct packed {
    logic [30:0] int_value;
    logic [31:0] float_bits;
  } out_item_t;

  typedef enum logic [0:0] {
    CMD_SEED = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FOLD1,
    ST_FOLD2,
    ST_NORM,
    ST_ROUND
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_FOLD1,
    OP_FOLD2,
    OP_NORM
  } op_t;

  typedef struct packed {
    logic norm_done;
  } dp_status_t;

endpackage

@@ hdl/mmsr_dp.sv @@
// Datapath: generator word, shared accumulator for multiply, fold and normalize.
// Depends on mmsr_pkg.
module mmsr_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mmsr_pkg::op_t         op,
  input  logic [31:0]           seed,
  output mmsr_pkg::dp_status_t  status,
  output mmsr_pkg::out_item_t   result
);

  logic [31:0] word_r, word_nxt;
  logic [46:0] acc_r, acc_nxt;
  logic [4:0]  pos_r, pos_nxt;

  logic [31:0] xw;
  logic [31:0] u;
  logic [31:0] fold1;
  logic [30:0] fold2;
  logic [30:0] red;
  logic [30:0] newv;
  logic [30:0] m;
  logic        rnd_up;
  logic [24:0] mant;
  logic [4:0]  pos_f;
  logic [7:0]  expo;

  always_comb begin
    xw    = word_r ^ mmsr_pkg::MASK_WORD;
    // negative x: add 2M to bring it to the same residue, below 2^32
    u     = xw[31] ? 32'({1'b0, xw} + mmsr_pkg::TWO_MOD) : xw;
    fold1 = 32'({16'd0, acc_r[46:31]}) + {1'b0, acc_r[30:0]};
    fold2 = 31'({30'd0, acc_r[31]}) + acc_r[30:0];
    red   = (fold2 == mmsr_pkg::MODULUS) ? 31'd0 : fold2;
    newv  = red ^ mmsr_pkg::MASK_WORD[30:0];
    m     = acc_r[30:0];

    word_nxt = word_r;
    acc_nxt  = acc_r;
    pos_nxt  = pos_r;
    unique case (op)
      mmsr_pkg::OP_NONE:  ;
      mmsr_pkg::OP_LOAD:  word_nxt = seed;
      mmsr_pkg::OP_MUL:   acc_nxt = 47'(mmsr_pkg::MULTIPLIER * u);
      mmsr_pkg::OP_FOLD1: acc_nxt = {15'd0, fold1};
      mmsr_pkg::OP_FOLD2: begin
        word_nxt = {1'b0, newv};
        acc_nxt  = {16'd0, newv};
        pos_nxt  = mmsr_pkg::TOP_POS;
      end
      mmsr_pkg::OP_NORM: begin
        if (m != 31'd0 && !m[30]) begin
          if (m[30:23] == 8'd0) begin
            acc_nxt = {16'd0, m << 8};
            pos_nxt = pos_r - 5'd8;
          end else begin
            acc_nxt = {16'd0, m << 1};
            pos_nxt = pos_r - 5'd1;
          end
        end
      end
      default: ;
    endcase

    status.norm_done = (m == 31'd0) || m[30];

    // round to nearest even on the normalized value
    rnd_up = m[6] && ((m[5:0] != 6'd0) || m[7]);
    mant   = {1'b0, m[30:7]} + 25'(rnd_up);
    pos_f  = mant[24] ? pos_r + 5'd1 : pos_r;
    expo   = mmsr_pkg::EXP_BASE + {3'd0, pos_f};
    result.int_value = word_r[30:0];
    if (m == 31'd0) begin
      result.float_bits = 32'd0;
    end else begin
      result.float_bits = {1'b0, expo, mant[24] ? 23'd0 : mant[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= 32'd0;
    end else begin
      word_r <= word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    pos_r <= pos_nxt;
  end

endmodule

@@ hdl/masked_minimal_standard_rng.sv @@
// Top level of the masked minimal-standard generator: sequencer and handshakes.
// Depends on mmsr_pkg and mmsr_dp.
//
//  channel | ports                           | direction
//  input   | in_valid, in_stall, in_data     | seed or draw item in
//  output  | out_valid, out_stall, out_data  | one result item per draw
//
// A seed item loads the generator word without leaving idle. A draw takes
// multiply, two folds, normalize (8- or 1-bit shifts until bit 30 is set or the
// value is zero, plus the done check) and round, its length set by the shared
// normalize shifter. Reset clears the generator word to zero. A pending result in
// the output register does not block a new item; the sequencer only waits in the
// round step while the output is stalled.
module masked_minimal_standard_rng (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mmsr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mmsr_pkg::out_item_t  out_data
);

  mmsr_pkg::state_t     state_r, state_nxt;
  mmsr_pkg::op_t        op;
  mmsr_pkg::dp_status_t status;
  mmsr_pkg::out_item_t  result;
  mmsr_pkg::out_item_t  out_data_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 load_out;
  logic                 accept;
  logic [31:0]          seed;

  assign in_stall  = (state_r != mmsr_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt = state_r;
    op        = mmsr_pkg::OP_NONE;
    load_out  = 1'b0;
    seed      = 32'(in_data.seed_value);
    unique case (state_r)
      mmsr_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.command == mmsr_pkg::CMD_DRAW) begin
            state_nxt = mmsr_pkg::ST_MUL;
          end else begin
            op = mmsr_pkg::OP_LOAD;
          end
        end
      end
      mmsr_pkg::ST_MUL: begin
        op        = mmsr_pkg::OP_MUL;
        state_nxt = mmsr_pkg::ST_FOLD1;
      end
      mmsr_pkg::ST_FOLD1: begin
        op        = mmsr_pkg::OP_FOLD1;
        state_nxt = mmsr_pkg::ST_FOLD2;
      end
      mmsr_pkg::ST_FOLD2: begin
        op        = mmsr_pkg::OP_FOLD2;
        state_nxt = mmsr_pkg::ST_NORM;
      end
      mmsr_pkg::ST_NORM: begin
        if (status.norm_done) begin
          state_nxt = mmsr_pkg::ST_ROUND;
        end else begin
          op = mmsr_pkg::OP_NORM;
        end
      end
      mmsr_pkg::ST_ROUND: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = mmsr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mmsr_pkg::ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmsr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= result;
    end
  end

  mmsr_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (op),
    .seed   (seed),
    .status (status),
    .result (result)
  );

endmodule

@@ tb/testbench.sv @@
// Testbench for the masked minimal-standard generator: drives seed and draw items,
// predicts each draw and checks the result stream. Depends on mmsr_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mmsr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mmsr_pkg::out_item_t out_data;

  masked_minimal_standard_rng DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  mmsr_pkg::in_item_t pending_items[$];
  mmsr_pkg::out_item_t expected_draws[$];
  logic [31:0] gen_word;
  int mismatches = 0;
  int draws_seen = 0;
  int seeds_sent = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic hold_drain = 1'b0;
  bit stim_done = 1'b0;

  localparam int CYCLE_LIMIT = 400000;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Round-to-nearest-even conversion of a 31-bit integer, scaled by 2^-31.
  function automatic logic [31:0] to_single(logic [30:0] v);
    int p;
    logic [31:0] m, rem, half;
    int s;
    if (v == 0) return 32'd0;
    p = 30;
    while (!v[p]) p--;
    if (p <= 23) begin
      m = 32'(v) << (23 - p);
    end else begin
      s = p - 23;
      m = 32'(v) >> s;
      rem = 32'(v) & ((32'd1 << s) - 1);
      half = 32'd1 << (s - 1);
      if (rem > half || (rem == half && m[0])) m++;
      if (m == 32'h0100_0000) begin
        m = m >> 1;
        p++;
      end
    end
    return (32'(96 + p) << 23) | (m & 32'h007F_FFFF);
  endfunction

  // Applies one item to the predicted generator word; queues a result on a draw.
  function automatic void predict_item(mmsr_pkg::in_item_t it);
    logic signed [31:0] x;
    longint r;
    mmsr_pkg::out_item_t o;
    if (it.command == mmsr_pkg::CMD_SEED) begin
      gen_word = it.seed_value;
      return;
    end
    x = gen_word ^ mmsr_pkg::MASK_WORD;
    r = (64'sd16807 * longint'(x)) % 64'sd2147483647;
    if (r < 0) r += 64'sd2147483647;
    gen_word = 32'(r) ^ mmsr_pkg::MASK_WORD;
    o.int_value = gen_word[30:0];
    o.float_bits = to_single(gen_word[30:0]);
    expected_draws.push_back(o);
  endfunction

  function automatic mmsr_pkg::in_item_t mk(logic cmd, logic [31:0] sv);
    mmsr_pkg::in_item_t it;
    it.command = cmd;
    it.seed_value = sv;
    return it;
  endfunction

  function automatic logic [31:0] rnd_seed();
    int k;
    k = $urandom_range(0, 9);
    case (k)
      0: return mmsr_pkg::MASK_WORD;
      1: return mmsr_pkg::MASK_WORD ^ 32'h7FFF_FFFF;
      2: return mmsr_pkg::MASK_WORD ^ 32'h8000_0000;
      3: return mmsr_pkg::MASK_WORD ^ 32'h8000_0001;
      4: return 32'h8000_0000 | $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        if (in_data.command == mmsr_pkg::CMD_SEED) seeds_sent <= seeds_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (hold_drain) begin
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          gap_left <= gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    mmsr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      draws_seen <= draws_seen + 1;
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: int %h float %h", out_data.int_value,
                   out_data.float_bits);
      end else begin
        want = expected_draws.pop_front();
        if (want.int_value !== out_data.int_value ||
            want.float_bits !== out_data.float_bits) begin
          mismatches++;
          if (mismatches <= 10)
            $display("draw mismatch: exp int %h float %h, got int %h float %h",
                     want.int_value, want.float_bits, out_data.int_value,
                     out_data.float_bits);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int n;
    gen_word = 32'd0;
    // directed: draw from reset word, fixed point, sign extremes
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'h0));
    pending_items.push_back(mk(mmsr_pkg::CMD_SEED, mmsr_pkg::MASK_WORD));
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'h0));
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'hFFFF_FFFF));
    pending_items.push_back(mk(mmsr_pkg::CMD_SEED, mmsr_pkg::MASK_WORD ^ 32'h7FFF_FFFF));
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'h0));
    pending_items.push_back(mk(mmsr_pkg::CMD_SEED, 32'h8000_0000));
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'h0));
    pending_items.push_back(mk(mmsr_pkg::CMD_SEED, 32'h7FFF_FFFF));
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'h0));
    pending_items.push_back(mk(mmsr_pkg::CMD_SEED, 32'hFFFF_FFFF));
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'h0));
    pending_items.push_back(mk(mmsr_pkg::CMD_SEED, mmsr_pkg::MASK_WORD ^ 32'h8000_0000));
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'h0));
    pending_items.push_back(mk(mmsr_pkg::CMD_SEED, mmsr_pkg::MASK_WORD ^ 32'h0000_0001));
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'h0));
    pending_items.push_back(mk(mmsr_pkg::CMD_SEED, 32'h0000_0000));
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'h0));
    pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, 32'hAAAA_5555));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !in_valid);
    // hold the sender until every draw so far has come back
    hold_drain = 1'b1;
    wait (expected_draws.size() == 0);
    hold_drain = 1'b0;
    n = 0;
    while (n < 750) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_items.push_back(mk(mmsr_pkg::CMD_SEED, rnd_seed()));
      end else begin
        pending_items.push_back(mk(mmsr_pkg::CMD_DRAW, $urandom));
      end
      n++;
      if (n % 250 == 0) begin
        wait (pending_items.size() == 0 && !in_valid);
      end
    end
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_draws.size() == 0);
    repeat (40) @(posedge clk);
    $display("Covered %0d draws and %0d reseeds, fixed point and sign extremes included.",
             draws_seen, seeds_sent);
    if (mismatches == 0 && expected_draws.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ files.f @@
hdl/mmsr_pkg.sv
hdl/mmsr_dp.sv
hdl/masked_minimal_standard_rng.sv
tb/testbench.sv
